// ===== src/scm_pkg.sv =====
// ----------------------------------------------------------------------------
// scm_pkg
// Shared types, phase codes and per-phase bus tables of the SCCB register
// access master.
// ----------------------------------------------------------------------------
package scm_pkg;

   // request codes
   localparam logic [1:0] OP_IDLE  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   // configuration register indexes (paddr bit 2)
   localparam logic CSR_IDX_DEVICE_ADDR = 1'b0;
   localparam logic CSR_IDX_HALF_BIT    = 1'b1;

   localparam int unsigned CSR_ADDR_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH = 32;

   localparam logic [7:0]  DEVICE_ADDR_RESET = 8'd66;
   localparam logic [15:0] HALF_BIT_RESET    = 16'd3600;

   // bus phases
   localparam logic [4:0] PH_IDLE  = 5'd0;
   localparam logic [4:0] PH_SH    = 5'd1;
   localparam logic [4:0] PH_SL    = 5'd2;
   localparam logic [4:0] PH_W0L   = 5'd3;
   localparam logic [4:0] PH_W0H   = 5'd4;
   localparam logic [4:0] PH_G0    = 5'd5;
   localparam logic [4:0] PH_W1L   = 5'd6;
   localparam logic [4:0] PH_W1H   = 5'd7;
   localparam logic [4:0] PH_G1    = 5'd8;
   localparam logic [4:0] PH_W2L   = 5'd9;
   localparam logic [4:0] PH_W2H   = 5'd10;
   localparam logic [4:0] PH_Q1    = 5'd11;
   localparam logic [4:0] PH_Q2    = 5'd12;
   localparam logic [4:0] PH_Q3    = 5'd13;
   localparam logic [4:0] PH_SL2   = 5'd14;
   localparam logic [4:0] PH_W3L   = 5'd15;
   localparam logic [4:0] PH_W3H   = 5'd16;
   localparam logic [4:0] PH_G3    = 5'd17;
   localparam logic [4:0] PH_RL    = 5'd18;
   localparam logic [4:0] PH_RH    = 5'd19;
   localparam logic [4:0] PH_N2    = 5'd20;
   localparam logic [4:0] PH_N3    = 5'd21;
   localparam logic [4:0] PH_P1    = 5'd22;
   localparam logic [4:0] PH_P2    = 5'd23;
   localparam logic [4:0] PH_P3    = 5'd24;
   localparam logic [4:0] PH_COUNT = 5'd25;

   // sda source per phase
   localparam logic [1:0] SDA_LOW  = 2'd0;
   localparam logic [1:0] SDA_HIGH = 2'd1;
   localparam logic [1:0] SDA_BIT  = 2'd2;

   localparam logic [3:0] BITS_PER_BYTE = 4'd8;

   typedef struct packed {
      logic [1:0] op;
      logic [7:0] reg_addr;
      logic [7:0] write_data;
      logic       sda_line;
   } req_item_type;

   typedef struct packed {
      logic       scl_release;
      logic       sda_release;
      logic       busy_res;
      logic       done_res;
      logic [7:0] read_data;
      logic [2:0] ack_missing;
      logic       bus_error;
   } rsp_item_type;

   typedef struct packed {
      logic [7:0]  device_addr;
      logic [15:0] half_bit_cycles;
   } cfg_type;

   // scl level per phase
   function automatic logic phase_scl(input logic [4:0] ph);
      logic lvl;
      unique case (ph)
         PH_W0L, PH_G0, PH_W1L, PH_G1, PH_W2L, PH_Q1, PH_W3L, PH_G3,
         PH_RL, PH_N2, PH_N3, PH_P1: lvl = 1'b0;
         default: lvl = 1'b1;
      endcase
      return lvl;
   endfunction

   // sda source per phase
   function automatic logic [1:0] phase_sda(input logic [4:0] ph);
      logic [1:0] kind;
      unique case (ph)
         PH_SL, PH_Q1, PH_Q2, PH_SL2, PH_N3, PH_P1, PH_P2: kind = SDA_LOW;
         PH_W0L, PH_W0H, PH_W1L, PH_W1H, PH_W2L, PH_W2H,
         PH_W3L, PH_W3H: kind = SDA_BIT;
         default: kind = SDA_HIGH;
      endcase
      return kind;
   endfunction

   // half periods per phase
   function automatic logic [2:0] phase_halves(input logic [4:0] ph);
      logic [2:0] n;
      unique case (ph)
         PH_G0, PH_G1, PH_G3: n = 3'd2;
         PH_Q3: n = 3'd4;
         default: n = 3'd1;
      endcase
      return n;
   endfunction

endpackage

// ===== src/scm_csr.sv =====
// ----------------------------------------------------------------------------
// scm_csr
// APB-style configuration registers: device address and half bit period.
// ----------------------------------------------------------------------------
module scm_csr (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [scm_pkg::CSR_ADDR_WIDTH-1:0]     csr_paddr,
   input  logic [scm_pkg::CSR_DATA_WIDTH-1:0]     csr_pwdata,
   output logic [scm_pkg::CSR_DATA_WIDTH-1:0]     csr_prdata,
   output logic                                   csr_pready,
   output scm_pkg::cfg_type                       cfg
);

   logic [7:0]  device_addr_ff;
   logic [15:0] half_bit_ff;
   logic        wr_en;
   logic        idx;

   assign csr_pready = 1'b1;
   assign idx        = csr_paddr[2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         device_addr_ff <= scm_pkg::DEVICE_ADDR_RESET;
         half_bit_ff    <= scm_pkg::HALF_BIT_RESET;
      end else if (wr_en) begin
         unique case (idx)
            scm_pkg::CSR_IDX_DEVICE_ADDR: device_addr_ff <= csr_pwdata[7:0];
            scm_pkg::CSR_IDX_HALF_BIT:    half_bit_ff    <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   // read mux
   always_comb begin
      unique case (idx)
         scm_pkg::CSR_IDX_DEVICE_ADDR:
            csr_prdata = {{(scm_pkg::CSR_DATA_WIDTH-8){1'b0}}, device_addr_ff};
         default:
            csr_prdata = {{(scm_pkg::CSR_DATA_WIDTH-16){1'b0}}, half_bit_ff};
      endcase
   end

   assign cfg.device_addr     = device_addr_ff;
   assign cfg.half_bit_cycles = half_bit_ff;

endmodule

// ===== src/scm_step.sv =====
// ----------------------------------------------------------------------------
// scm_step
// Bus sequencer: applies one timer tick to the transfer state and registers
// the resulting bus levels and status.
// ----------------------------------------------------------------------------
module scm_step (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  scm_pkg::req_item_type item,
   input  scm_pkg::cfg_type      cfg,
   output scm_pkg::rsp_item_type result
);

   logic [4:0]  phase_ff,   phase_in;
   logic [3:0]  bit_ff,     bit_in;
   logic [7:0]  shift_ff,   shift_in;
   logic [15:0] timer_ff,   timer_in;
   logic        is_read_ff, is_read_in;
   logic [7:0]  addr_ff,    addr_in;
   logic [7:0]  data_ff,    data_in;
   logic [2:0]  ack_ff,     ack_in;
   scm_pkg::rsp_item_type result_ff, result_in;

   // next state for one tick
   always_comb begin
      logic [4:0]  ph;
      logic [15:0] hcyc;
      logic [16:0] t;
      logic        done;
      logic        err;
      logic [1:0]  kind;

      ph         = (phase_ff >= scm_pkg::PH_COUNT) ? scm_pkg::PH_IDLE : phase_ff;
      hcyc       = (cfg.half_bit_cycles == 16'd0) ? 16'd1 : cfg.half_bit_cycles;
      t          = {1'b0, timer_ff} + 17'd1;
      done       = 1'b0;
      err        = 1'b0;
      phase_in   = ph;
      bit_in     = bit_ff;
      shift_in   = shift_ff;
      timer_in   = timer_ff;
      is_read_in = is_read_ff;
      addr_in    = addr_ff;
      data_in    = data_ff;
      ack_in     = ack_ff;

      if (ph == scm_pkg::PH_IDLE) begin
         // start of a transfer
         if (item.op == scm_pkg::OP_WRITE || item.op == scm_pkg::OP_READ) begin
            is_read_in = (item.op == scm_pkg::OP_READ);
            addr_in    = item.reg_addr;
            data_in    = item.write_data;
            ack_in     = 3'd0;
            shift_in   = cfg.device_addr;
            timer_in   = 16'd0;
            phase_in   = scm_pkg::PH_SH;
            bit_in     = 4'd0;
         end
      end else if (t < {1'b0, hcyc}) begin
         timer_in = t[15:0];
      end else begin
         timer_in = 16'd0;
         if ({1'b0, bit_ff} + 5'd1 < {2'b0, scm_pkg::phase_halves(ph)}) begin
            // multi-half segment still running
            bit_in = bit_ff + 4'd1;
         end else begin
            unique case (ph)
               scm_pkg::PH_SH, scm_pkg::PH_Q3: begin
                  if (!item.sda_line) begin
                     err = 1'b1;
                  end else begin
                     phase_in = (ph == scm_pkg::PH_SH) ? scm_pkg::PH_SL : scm_pkg::PH_SL2;
                     bit_in   = 4'd0;
                  end
               end
               scm_pkg::PH_SL, scm_pkg::PH_SL2: begin
                  if (item.sda_line) begin
                     err = 1'b1;
                  end else begin
                     shift_in = (ph == scm_pkg::PH_SL) ? cfg.device_addr
                                                       : (cfg.device_addr | 8'h01);
                     phase_in = (ph == scm_pkg::PH_SL) ? scm_pkg::PH_W0L : scm_pkg::PH_W3L;
                     bit_in   = 4'd0;
                  end
               end
               scm_pkg::PH_W0L, scm_pkg::PH_W1L, scm_pkg::PH_W2L, scm_pkg::PH_W3L,
               scm_pkg::PH_RL: begin
                  phase_in = ph + 5'd1;
               end
               // end of scl-high half of a sent bit, ninth bit is the ack
               scm_pkg::PH_W0H, scm_pkg::PH_W1H, scm_pkg::PH_W2H, scm_pkg::PH_W3H: begin
                  if (bit_ff < scm_pkg::BITS_PER_BYTE) begin
                     shift_in = {shift_ff[6:0], 1'b0};
                     bit_in   = bit_ff + 4'd1;
                     phase_in = ph - 5'd1;
                  end else begin
                     bit_in = 4'd0;
                     unique case (ph)
                        scm_pkg::PH_W0H: begin
                           ack_in[0] = ack_ff[0] | item.sda_line;
                           phase_in  = scm_pkg::PH_G0;
                        end
                        scm_pkg::PH_W1H: begin
                           ack_in[1] = ack_ff[1] | item.sda_line;
                           phase_in  = scm_pkg::PH_G1;
                        end
                        scm_pkg::PH_W2H: begin
                           ack_in[2] = ack_ff[2] | item.sda_line;
                           phase_in  = scm_pkg::PH_P1;
                        end
                        default: begin
                           ack_in[2] = ack_ff[2] | item.sda_line;
                           phase_in  = scm_pkg::PH_G3;
                        end
                     endcase
                  end
               end
               scm_pkg::PH_G0: begin
                  shift_in = addr_ff;
                  phase_in = scm_pkg::PH_W1L;
                  bit_in   = 4'd0;
               end
               scm_pkg::PH_G1: begin
                  bit_in = 4'd0;
                  if (is_read_ff) begin
                     phase_in = scm_pkg::PH_Q1;
                  end else begin
                     shift_in = data_ff;
                     phase_in = scm_pkg::PH_W2L;
                  end
               end
               scm_pkg::PH_G3: begin
                  shift_in = 8'd0;
                  phase_in = scm_pkg::PH_RL;
                  bit_in   = 4'd0;
               end
               // sample a read bit at the end of the scl-high half
               scm_pkg::PH_RH: begin
                  if (bit_ff < scm_pkg::BITS_PER_BYTE) begin
                     shift_in = {shift_ff[6:0], item.sda_line};
                     bit_in   = bit_ff + 4'd1;
                     phase_in = scm_pkg::PH_RL;
                  end else begin
                     phase_in = scm_pkg::PH_N2;
                     bit_in   = 4'd0;
                  end
               end
               scm_pkg::PH_P3: begin
                  done     = 1'b1;
                  phase_in = scm_pkg::PH_IDLE;
                  bit_in   = 4'd0;
               end
               default: begin
                  phase_in = ph + 5'd1;
                  bit_in   = 4'd0;
               end
            endcase
            // bus fault at a start or repeated start aborts the transfer
            if (err) begin
               done     = 1'b1;
               phase_in = scm_pkg::PH_IDLE;
               bit_in   = 4'd0;
            end
         end
      end

      // bus levels and status after the tick
      kind                  = scm_pkg::phase_sda(phase_in);
      result_in.scl_release = scm_pkg::phase_scl(phase_in);
      if (kind == scm_pkg::SDA_BIT) begin
         result_in.sda_release = (bit_in < scm_pkg::BITS_PER_BYTE) ? shift_in[7] : 1'b1;
      end else begin
         result_in.sda_release = kind[0];
      end
      result_in.busy_res    = (phase_in != scm_pkg::PH_IDLE);
      result_in.done_res    = done;
      result_in.read_data   = (done && is_read_in && !err) ? shift_in : 8'd0;
      result_in.ack_missing = done ? ack_in : 3'd0;
      result_in.bus_error   = err;
   end

   // transfer state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= scm_pkg::PH_IDLE;
         bit_ff     <= 4'd0;
         shift_ff   <= 8'd0;
         timer_ff   <= 16'd0;
         is_read_ff <= 1'b0;
         addr_ff    <= 8'd0;
         data_ff    <= 8'd0;
         ack_ff     <= 3'd0;
      end else if (advance) begin
         phase_ff   <= phase_in;
         bit_ff     <= bit_in;
         shift_ff   <= shift_in;
         timer_ff   <= timer_in;
         is_read_ff <= is_read_in;
         addr_ff    <= addr_in;
         data_ff    <= data_in;
         ack_ff     <= ack_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

// ===== src/sccb_register_access_master.sv =====
// ----------------------------------------------------------------------------
// sccb_register_access_master
// Open-drain SCCB master for register writes and reads, one bus timer tick
// per transfer on the request channel, one status transfer per tick back.
// ----------------------------------------------------------------------------
// A tick's result is offered after its transfer is accepted, through the input
//   register, then the sequencer result register. Throughput: one tick per cycle
//   while rsp_stall is low; the sequencer state updates once per tick.
// Reset: synchronous, active high; sequencer idle, no result offered until
//   the first tick, registers back to device address 66 and half bit period 3600.
module sccb_register_access_master (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_op,
   input  logic [7:0]                          req_reg_addr,
   input  logic [7:0]                          req_write_data,
   input  logic                                req_sda_line,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_scl_release,
   output logic                                rsp_sda_release,
   output logic                                rsp_busy_res,
   output logic                                rsp_done_res,
   output logic [7:0]                          rsp_read_data,
   output logic [2:0]                          rsp_ack_missing,
   output logic                                rsp_bus_error,
   // configuration port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [scm_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [scm_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic [scm_pkg::CSR_DATA_WIDTH-1:0]  csr_prdata,
   output logic                                csr_pready
);

   scm_pkg::cfg_type      cfg;
   scm_pkg::req_item_type item_ff, item_in;
   scm_pkg::rsp_item_type result;
   logic                  in_valid_ff;
   logic                  rsp_valid_ff;
   logic                  out_free;
   logic                  advance;
   logic                  req_take;

   scm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // pipeline handshake
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   assign item_in.op         = req_op;
   assign item_in.reg_addr   = req_reg_addr;
   assign item_in.write_data = req_write_data;
   assign item_in.sda_line   = req_sda_line;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff <= item_in;
      end
   end

   scm_step u_step (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (item_ff),
      .cfg     (cfg),
      .result  (result)
   );

   // result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_scl_release = result.scl_release;
   assign rsp_sda_release = result.sda_release;
   assign rsp_busy_res    = result.busy_res;
   assign rsp_done_res    = result.done_res;
   assign rsp_read_data   = result.read_data;
   assign rsp_ack_missing = result.ack_missing;
   assign rsp_bus_error   = result.bus_error;

endmodule
